// ===== rtl/core/fcrc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the CRC-32 byte step for the frame receiver.
package fcrc_pkg;

    localparam int SIZE_BYTES   = 4;
    localparam int NAME_BYTES   = 12;
    localparam int HDR_BYTES    = SIZE_BYTES + NAME_BYTES;
    localparam int HDR_IDX_W    = $clog2(HDR_BYTES);
    localparam int RECORD_EXTRA = 21;
    localparam int LEN_W        = 32;
    localparam int MAXLEN_W     = 25;
    localparam int COUNT_W      = 25;
    localparam int OFFSET_W     = 24;
    localparam int SIZE_W       = 25;
    localparam int CRC_W        = 32;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [CRC_W-1:0]    CRC_POLY       = 32'hEDB88320;
    localparam logic [CRC_W-1:0]    CRC_ONES       = 32'hFFFFFFFF;
    localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RST = 25'd16777216;

    typedef enum logic [1:0] {
        KIND_STORE  = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CMD_STORE,
        CMD_STORE_DONE,
        CMD_DONE,
        CMD_REJECT
    } cmd_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [OFFSET_W-1:0] offset;
        logic [7:0]          data;
        logic [CRC_W-1:0]    crc;
        logic [SIZE_W-1:0]   size;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/fcrc_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input words and result words.
interface fcrc_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface fcrc_out_if;
    logic                            valid;
    logic                            ready;
    fcrc_pkg::kind_t                 kind;
    logic [fcrc_pkg::OFFSET_W-1:0]   offset;
    logic [7:0]                      content_byte;
    logic [fcrc_pkg::CRC_W-1:0]      file_crc;
    logic [fcrc_pkg::SIZE_W-1:0]     stored_size;
    logic                            last;

    modport source (output valid, output kind, output offset, output content_byte,
                    output file_crc, output stored_size, output last, input ready);
    modport sink (input valid, input kind, input offset, input content_byte,
                  input file_crc, input stored_size, input last, output ready);
endinterface

// ===== rtl/core/fcrc_front.sv =====
`timescale 1ns / 1ps
// Front end: header parsing, length check, running CRC and command generation.
module fcrc_front #(
    parameter int MAX_FILE_BYTES = 16777216
) (
    input  logic                           clk,
    input  logic                           rst_n,
    fcrc_in_if.sink                        stream,
    input  logic                           cfg_we,
    input  logic [fcrc_pkg::MAXLEN_W-1:0]  cfg_wdata,
    input  logic                           q_full,
    output fcrc_pkg::push_t                push
);
    import fcrc_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_DATA,
        PH_DONE,
        PH_REJECT
    } phase_t;

    localparam logic [HDR_IDX_W-1:0] HDR_LAST  = HDR_IDX_W'(HDR_BYTES - 1);
    localparam logic [HDR_IDX_W-1:0] SIZE_END  = HDR_IDX_W'(SIZE_BYTES);
    localparam logic [LEN_W-1:0]     FILE_CAP  = LEN_W'(MAX_FILE_BYTES);

    phase_t               phase_reg, phase_next;
    logic [HDR_IDX_W-1:0] hidx_reg, hidx_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 carry_reg, carry_next;
    logic                 name_ended_reg, name_ended_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [CRC_W-1:0]     crc_reg, crc_next;
    logic [MAXLEN_W-1:0]  max_length_reg;

    logic                 accept;
    logic [8:0]           size_sum;
    logic                 name_zero;
    logic [7:0]           feed;
    logic [CRC_W-1:0]     crc_a;
    logic [CRC_W-1:0]     crc_b;
    logic [LEN_W-1:0]     limit;
    logic [COUNT_W-1:0]   count_inc;
    logic [SIZE_W-1:0]    rec_size;

    assign stream.ready = !q_full;
    assign accept       = stream.valid && !q_full;

    always_comb
    begin
        size_sum  = {1'b0, stream.data_byte} + ((hidx_reg == '0) ? 9'(RECORD_EXTRA) : 9'd0)
                    + {8'd0, carry_reg};
        name_zero = name_ended_reg || (stream.data_byte == 8'd0);
        if (phase_reg == PH_HEADER && hidx_reg < SIZE_END)
        begin
            feed = size_sum[7:0];
        end
        else if (phase_reg == PH_HEADER && name_zero)
        begin
            feed = 8'd0;
        end
        else
        begin
            feed = stream.data_byte;
        end
        crc_a     = crc_byte(crc_reg, feed);
        crc_b     = crc_byte(crc_a, 8'd0);
        limit     = ({7'd0, max_length_reg} > FILE_CAP) ? FILE_CAP : {7'd0, max_length_reg};
        count_inc = count_reg + COUNT_W'(1);
        rec_size  = len_reg[SIZE_W-1:0] + SIZE_W'(RECORD_EXTRA);

        phase_next      = phase_reg;
        hidx_next       = hidx_reg;
        len_next        = len_reg;
        carry_next      = carry_reg;
        name_ended_next = name_ended_reg;
        count_next      = count_reg;
        crc_next        = crc_reg;
        push            = '0;
        push.entry.cmd  = CMD_STORE;

        if (accept)
        begin
            if (stream.op)
            begin
                phase_next      = PH_HEADER;
                hidx_next       = '0;
                len_next        = '0;
                carry_next      = 1'b0;
                name_ended_next = 1'b0;
                count_next      = '0;
                crc_next        = CRC_ONES;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        crc_next = crc_a;
                        if (hidx_reg < SIZE_END)
                        begin
                            len_next[8*hidx_reg[1:0] +: 8] = stream.data_byte;
                            carry_next = size_sum[8];
                        end
                        else if (name_zero)
                        begin
                            name_ended_next = 1'b1;
                        end
                        if (hidx_reg == HDR_LAST)
                        begin
                            crc_next  = crc_b;
                            hidx_next = '0;
                            if (len_reg > limit)
                            begin
                                phase_next     = PH_REJECT;
                                push.valid     = 1'b1;
                                push.entry.cmd = CMD_REJECT;
                            end
                            else if (len_reg == '0)
                            begin
                                phase_next      = PH_DONE;
                                push.valid      = 1'b1;
                                push.entry.cmd  = CMD_DONE;
                                push.entry.crc  = crc_b ^ CRC_ONES;
                                push.entry.size = rec_size;
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                                count_next = '0;
                            end
                        end
                        else
                        begin
                            hidx_next = hidx_reg + HDR_IDX_W'(1);
                        end
                    end
                    PH_DATA:
                    begin
                        crc_next          = crc_a;
                        count_next        = count_inc;
                        push.valid        = 1'b1;
                        push.entry.offset = count_reg[OFFSET_W-1:0];
                        push.entry.data   = stream.data_byte;
                        if ({7'd0, count_inc} >= len_reg)
                        begin
                            phase_next      = PH_DONE;
                            push.entry.cmd  = CMD_STORE_DONE;
                            push.entry.crc  = crc_a ^ CRC_ONES;
                            push.entry.size = rec_size;
                        end
                    end
                    PH_DONE, PH_REJECT:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            hidx_reg       <= '0;
            len_reg        <= '0;
            carry_reg      <= 1'b0;
            name_ended_reg <= 1'b0;
            count_reg      <= '0;
            crc_reg        <= CRC_ONES;
            max_length_reg <= MAX_LENGTH_RST;
        end
        else
        begin
            phase_reg      <= phase_next;
            hidx_reg       <= hidx_next;
            len_reg        <= len_next;
            carry_reg      <= carry_next;
            name_ended_reg <= name_ended_next;
            count_reg      <= count_next;
            crc_reg        <= crc_next;
            if (cfg_we)
            begin
                max_length_reg <= cfg_wdata;
            end
        end
    end

endmodule

// ===== rtl/core/fcrc_queue.sv =====
`timescale 1ns / 1ps
// Short command queue between the front end and the result stage.
module fcrc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  fcrc_pkg::push_t  push,
    input  logic             pop,
    output logic             full,
    output logic             q_valid,
    output fcrc_pkg::entry_t head
);
    import fcrc_pkg::*;

    entry_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_pop;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = mem[rptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wptr_next  = push.valid ? wptr_reg + QPTR_W'(1) : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + QPTR_W'(1) : rptr_reg;
        count_next = count_reg + (QPTR_W+1)'(push.valid) - (QPTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem[wptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/fcrc_back.sv =====
`timescale 1ns / 1ps
// Result stage: expand queued commands into result words behind an output register.
module fcrc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  fcrc_pkg::entry_t head,
    output logic             pop,
    fcrc_out_if.source       result
);
    import fcrc_pkg::*;

    typedef enum logic {
        BK_FIRST,
        BK_SECOND
    } half_t;

    half_t               half_reg, half_next;
    logic                valid_reg, valid_next;
    kind_t               kind_reg, kind_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [7:0]          byte_reg, byte_next;
    logic [CRC_W-1:0]    crc_reg, crc_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic                last_reg, last_next;
    logic                load;

    assign load = !valid_reg || result.ready;

    always_comb
    begin
        half_next   = half_reg;
        valid_next  = valid_reg;
        kind_next   = kind_reg;
        offset_next = offset_reg;
        byte_next   = byte_reg;
        crc_next    = crc_reg;
        size_next   = size_reg;
        last_next   = last_reg;
        pop         = 1'b0;
        if (load)
        begin
            valid_next  = q_valid;
            offset_next = '0;
            byte_next   = '0;
            crc_next    = '0;
            size_next   = '0;
            last_next   = 1'b1;
            kind_next   = KIND_STORE;
            if (q_valid)
            begin
                pop = 1'b1;
                unique case (head.cmd)
                    CMD_STORE:
                    begin
                        offset_next = head.offset;
                        byte_next   = head.data;
                    end
                    CMD_STORE_DONE:
                    begin
                        if (half_reg == BK_FIRST)
                        begin
                            offset_next = head.offset;
                            byte_next   = head.data;
                            last_next   = 1'b0;
                            half_next   = BK_SECOND;
                            pop         = 1'b0;
                        end
                        else
                        begin
                            kind_next = KIND_DONE;
                            crc_next  = head.crc;
                            size_next = head.size;
                            half_next = BK_FIRST;
                        end
                    end
                    CMD_DONE:
                    begin
                        kind_next = KIND_DONE;
                        crc_next  = head.crc;
                        size_next = head.size;
                    end
                    CMD_REJECT:
                    begin
                        kind_next = KIND_REJECT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg   <= BK_FIRST;
            valid_reg  <= 1'b0;
            kind_reg   <= KIND_STORE;
            offset_reg <= '0;
            byte_reg   <= '0;
            crc_reg    <= '0;
            size_reg   <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            half_reg   <= half_next;
            valid_reg  <= valid_next;
            kind_reg   <= kind_next;
            offset_reg <= offset_next;
            byte_reg   <= byte_next;
            crc_reg    <= crc_next;
            size_reg   <= size_next;
            last_reg   <= last_next;
        end
    end

    assign result.valid        = valid_reg;
    assign result.kind         = kind_reg;
    assign result.offset       = offset_reg;
    assign result.content_byte = byte_reg;
    assign result.file_crc     = crc_reg;
    assign result.stored_size  = size_reg;
    assign result.last         = last_reg;

endmodule

// ===== rtl/core/file_frame_receiver_crc32.sv =====
`timescale 1ns / 1ps
// Top level of the length-prefixed frame receiver with CRC-32.
// A stream word's result passes through the command queue, then the output register.
// Throughput: one stream word per cycle while the command queue is not full; the final content
// byte yields two result words, both drained through the single result register.
// Reset clears parsing state, the CRC to all ones, the queue and the output register,
// and sets max_length to 16777216.
module file_frame_receiver_crc32 #(
    parameter int MAX_FILE_BYTES = 16777216
) (
    input  logic                          clk,
    input  logic                          rst_n,
    fcrc_in_if.sink                       stream,
    fcrc_out_if.source                    result,
    input  logic                          cfg_we,
    input  logic [fcrc_pkg::MAXLEN_W-1:0] cfg_wdata
);
    import fcrc_pkg::*;

    push_t  push;
    entry_t head;
    logic   q_full;
    logic   q_valid;
    logic   pop;

    fcrc_front #(
        .MAX_FILE_BYTES (MAX_FILE_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .push      (push)
    );

    fcrc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .pop     (pop),
        .full    (q_full),
        .q_valid (q_valid),
        .head    (head)
    );

    fcrc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .head    (head),
        .pop     (pop),
        .result  (result)
    );

endmodule
